// ----- hdl/sh13_pkg.sv -----
package sh13_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [WordW-1:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [WordW-1:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [WordW-1:0] SipC3 = 64'h7465646279746573;

  localparam logic [7:0] FinalXor = 8'hff;

  // Finalization rounds done by the back end.
  localparam int unsigned FinalRounds = 3;

  // Default depth of the queue between the front and back ends.
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic {
    RegKeyLow  = 1'b0,
    RegKeyHigh = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
  } sip_state_t;

  // One finished compression, waiting for finalization.
  typedef struct packed {
    logic       empty_msg;
    sip_state_t lanes;
  } fin_job_t;

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] x,
                                              input int unsigned s);
    return (x << s) | (x >> (WordW - s));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v2 = r.v2 + r.v3;
    r.v1 = rotl64(r.v1, 13) ^ r.v0;
    r.v3 = rotl64(r.v3, 16) ^ r.v2;
    r.v0 = rotl64(r.v0, 32);
    r.v2 = r.v2 + r.v1;
    r.v0 = r.v0 + r.v3;
    r.v1 = rotl64(r.v1, 17) ^ r.v2;
    r.v3 = rotl64(r.v3, 21) ^ r.v0;
    r.v2 = rotl64(r.v2, 32);
    return r;
  endfunction

endpackage

// ----- hdl/sh13_fifo.sv -----
module sh13_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/sh13_front.sv -----
module sh13_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index_i,
  input  logic [63:0]              cfg_data_i,
  input  logic                     push,
  output logic                     full,
  input  logic [63:0]              word_i,
  input  logic [2:0]               byte_count_i,
  input  logic                     last_i,
  output logic                     job_push_o,
  output sh13_pkg::fin_job_t       job_o,
  input  logic                     job_full_i
);

  logic [63:0]          key_low_q;
  logic [63:0]          key_high_q;
  sh13_pkg::sip_state_t lanes_q, lanes_d;
  logic [7:0]           len_q, len_d;
  logic                 started_q, started_d;

  sh13_pkg::sip_state_t base;
  sh13_pkg::sip_state_t absorbed;
  logic [7:0]           len_base;
  logic [63:0]          tail;
  logic [63:0]          msg;
  logic                 accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_valid) begin
      case (sh13_pkg::cfg_reg_e'(cfg_index_i))
        sh13_pkg::RegKeyLow:  key_low_q  <= cfg_data_i;
        sh13_pkg::RegKeyHigh: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Every word waits while the job queue is full, final or not.
  assign full   = job_full_i;
  assign accept = push & ~full;

  always_comb begin
    if (started_q) begin
      base     = lanes_q;
      len_base = len_q;
    end else begin
      base.v0  = key_low_q ^ sh13_pkg::SipC0;
      base.v1  = key_high_q ^ sh13_pkg::SipC1;
      base.v2  = key_low_q ^ sh13_pkg::SipC2;
      base.v3  = key_high_q ^ sh13_pkg::SipC3;
      len_base = '0;
    end

    for (int i = 0; i < 8; i++) begin
      tail[8*i +: 8] = (4'(i) < {1'b0, byte_count_i}) ? word_i[8*i +: 8] : 8'h00;
    end

    if (last_i) begin
      len_d = len_base + {5'b0, byte_count_i};
      msg   = {len_d, tail[55:0]};
    end else begin
      len_d = len_base + 8'd8;
      msg   = word_i;
    end

    absorbed    = base;
    absorbed.v3 = absorbed.v3 ^ msg;
    absorbed    = sh13_pkg::sip_round(absorbed);
    absorbed.v0 = absorbed.v0 ^ msg;

    job_o.lanes    = absorbed;
    job_o.lanes.v2 = absorbed.v2 ^ {56'b0, sh13_pkg::FinalXor};
    job_o.empty_msg = ~started_q & (byte_count_i == 3'd0);
    job_push_o     = accept & last_i;

    lanes_d   = absorbed;
    started_d = started_q;
    if (accept) begin
      started_d = ~last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !last_i) begin
      lanes_q <= lanes_d;
      len_q   <= len_d;
    end
  end

  a_last_ends_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> !started_q)
    else $error("message still open after its final word");

  a_word_opens_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last_i |=> started_q)
    else $error("message not open after a non-final word");

endmodule

// ----- hdl/sh13_back.sv -----
module sh13_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sh13_pkg::fin_job_t job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        hash_o
);

  localparam int unsigned RndW = (sh13_pkg::FinalRounds > 1) ?
                                 $clog2(sh13_pkg::FinalRounds) : 1;
  localparam logic [RndW-1:0] LastRnd = RndW'(sh13_pkg::FinalRounds - 1);

  logic                 busy_q, busy_d;
  logic [RndW-1:0]      rnd_q, rnd_d;
  sh13_pkg::sip_state_t work_q, work_d;
  logic                 empty_msg_q;
  logic                 res_valid_q, res_valid_d;
  logic [63:0]          hash_q, hash_d;

  sh13_pkg::sip_state_t rounded;
  logic                 slot_free;
  logic                 done;
  logic                 load;

  assign rounded   = sh13_pkg::sip_round(work_q);
  assign slot_free = ~res_valid_q | pop;
  assign done      = busy_q & (rnd_q == LastRnd) & slot_free;
  assign load      = (~busy_q | done) & ~job_empty_i;
  assign job_pop_o = load;

  assign empty  = ~res_valid_q;
  assign hash_o = hash_q;

  always_comb begin
    busy_d      = busy_q;
    rnd_d       = rnd_q;
    work_d      = work_q;
    res_valid_d = res_valid_q;
    hash_d      = hash_q;

    if (res_valid_q && pop) begin
      res_valid_d = 1'b0;
    end

    if (busy_q && rnd_q != LastRnd) begin
      work_d = rounded;
      rnd_d  = rnd_q + 1'b1;
    end

    if (done) begin
      busy_d      = 1'b0;
      res_valid_d = 1'b1;
      hash_d      = empty_msg_q ? '0 : (rounded.v0 ^ rounded.v1 ^ rounded.v2 ^ rounded.v3);
    end

    if (load) begin
      busy_d = 1'b1;
      rnd_d  = '0;
      work_d = job_i.lanes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rnd_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rnd_q       <= rnd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    hash_q <= hash_d;
    if (load) begin
      empty_msg_q <= job_i.empty_msg;
    end
  end

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !pop |=> res_valid_q && $stable(hash_q))
    else $error("waiting result changed before it was taken");

  a_rounds_continue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && rnd_q != LastRnd |=> busy_q && rnd_q == $past(rnd_q) + 1'b1)
    else $error("finalization stopped before its last round");

endmodule

// ----- hdl/siphash_1_3_keyed_hash.sv -----
// Channel    Direction  Handshake              Payload
// config     in         cfg_valid / cfg_ready  cfg_index_i, cfg_data_i
// message    in         push / full            word_i, byte_count_i, last_i
// result     out        empty / pop            hash_o
//
// The front end absorbs one message word per cycle, while the job queue is not full,
// with one compression round. A final word hands its lanes to a small queue; the
// back end runs the three finalization rounds one after another on its single shared
// round unit, and takes the next job from the queue only as it finishes the last round.
// Reset is asynchronous and active low; it clears keys, the open message and the queues.
// full rises only while the job queue is full; the finished hash waits in an output
// register while the back end works on the next job, up to that job's last round.
module siphash_1_3_keyed_hash #(
  parameter int unsigned QueueDepth = sh13_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [63:0] word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] hash_o
);

  localparam int unsigned JobW = $bits(sh13_pkg::fin_job_t);

  sh13_pkg::fin_job_t job_in;
  sh13_pkg::fin_job_t job_out;
  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_empty;

  sh13_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .word_i       (word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .job_push_o   (job_push),
    .job_o        (job_in),
    .job_full_i   (job_full)
  );

  sh13_fifo #(
    .Width (JobW),
    .Depth (QueueDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  sh13_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .hash_o      (hash_o)
  );

endmodule

// ----- dv/siphash_result_checker.sv -----
module siphash_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [63:0] word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [63:0] hash_i,
  output int          pending_o,
  output int          fail_count_o
);

  localparam logic [63:0] InitC0 = 64'h736f6d6570736575;
  localparam logic [63:0] InitC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] InitC2 = 64'h6c7967656e657261;
  localparam logic [63:0] InitC3 = 64'h7465646279746573;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lane_set_t;

  logic [63:0] key_k0;
  logic [63:0] key_k1;
  lane_set_t   lanes;
  logic [7:0]  msg_len;
  logic        msg_open;
  logic [63:0] expected_hashes[$];
  logic [63:0] want;
  int          mismatches;

  function automatic logic [63:0] rol(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic lane_set_t sip_mix(input lane_set_t s);
    lane_set_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v2 = r.v2 + r.v3;
    r.v1 = rol(r.v1, 13) ^ r.v0;
    r.v3 = rol(r.v3, 16) ^ r.v2;
    r.v0 = rol(r.v0, 32);
    r.v2 = r.v2 + r.v1;
    r.v0 = r.v0 + r.v3;
    r.v1 = rol(r.v1, 17) ^ r.v2;
    r.v3 = rol(r.v3, 21) ^ r.v0;
    r.v2 = rol(r.v2, 32);
    return r;
  endfunction

  task automatic compress(input logic [63:0] m);
    lanes.v3 = lanes.v3 ^ m;
    lanes    = sip_mix(lanes);
    lanes.v0 = lanes.v0 ^ m;
  endtask

  task automatic predict_hash(input logic [63:0] w, input logic [2:0] cnt, input logic lst);
    logic [63:0] tail;
    logic [63:0] blk;
    // A lone tail with no bytes is an empty message and hashes to zero.
    if (lst && !msg_open && cnt == 3'd0) begin
      expected_hashes.push_back(64'd0);
      return;
    end
    // Keys are sampled only when a message opens.
    if (!msg_open) begin
      lanes.v0 = key_k0 ^ InitC0;
      lanes.v1 = key_k1 ^ InitC1;
      lanes.v2 = key_k0 ^ InitC2;
      lanes.v3 = key_k1 ^ InitC3;
      msg_len  = 8'd0;
      msg_open = 1'b1;
    end
    if (!lst) begin
      compress(w);
      msg_len = msg_len + 8'd8;
      return;
    end
    tail    = (cnt == 3'd0) ? 64'd0 : (w & ((64'd1 << {cnt, 3'b000}) - 64'd1));
    msg_len = msg_len + {5'd0, cnt};
    blk     = {msg_len, 56'd0} | tail;
    compress(blk);
    lanes.v2 = lanes.v2 ^ 64'hff;
    repeat (3) lanes = sip_mix(lanes);
    expected_hashes.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
    msg_open = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_k0     = '0;
      key_k1     = '0;
      lanes      = '0;
      msg_len    = '0;
      msg_open   = 1'b0;
      mismatches = 0;
      expected_hashes.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // A transaction at the same edge as a key write still sees the old key.
      if (push_i && !full_i) begin
        predict_hash(word_i, byte_count_i, last_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == sh13_pkg::RegKeyLow) begin
          key_k0 = cfg_data_i;
        end else begin
          key_k1 = cfg_data_i;
        end
      end
      if (pop_i && !empty_i) begin
        if (expected_hashes.size() == 0) begin
          $error("hash: expected none, actual %h", hash_i);
          mismatches++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_i !== want) begin
            $error("hash: expected %h, actual %h", want, hash_i);
            mismatches++;
          end
        end
      end
      pending_o    <= expected_hashes.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- dv/tb_siphash_1_3_keyed_hash.sv -----
module tb_siphash_1_3_keyed_hash;

  localparam int ItemTarget    = 750;
  localparam int PhaseItems    = 150;
  localparam int SettleCycles  = 24;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;
  localparam logic [63:0] Ones = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid;
  logic                cfg_ready;
  sh13_pkg::cfg_reg_e  cfg_index;
  logic [63:0]         cfg_data;
  logic                push;
  logic                full;
  logic [63:0]         word;
  logic [2:0]          byte_count;
  logic                last;
  logic                empty;
  logic                pop;
  logic [63:0]         hash;

  int pending;
  int fail_count;
  int items_sent;
  int stall_cycles;
  bit idle_en;
  bit hold_go;
  bit hold_done;

  siphash_1_3_keyed_hash u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push        (push),
    .full        (full),
    .word_i      (word),
    .byte_count_i(byte_count),
    .last_i      (last),
    .empty       (empty),
    .pop         (pop),
    .hash_o      (hash)
  );

  siphash_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push_i      (push),
    .full_i      (full),
    .word_i      (word),
    .byte_count_i(byte_count),
    .last_i      (last),
    .empty_i     (empty),
    .pop_i       (pop),
    .hash_i      (hash),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("siphash_1_3_keyed_hash test failed");
      $finish;
    end
  end

  // The receiver; it also owns the long hold-off that lets the block fill up.
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      pop <= !(idle_en && $urandom_range(99) < 14);
    end
  end

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return Ones;
    end else if (pick < 16) begin
      return 64'd0;
    end
    return {$urandom, $urandom};
  endfunction

  // push stays high across back-to-back transactions and drops only in a gap.
  task automatic send_item(input logic [63:0] w, input logic [2:0] cnt, input logic lst);
    while (idle_en && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    word       <= w;
    byte_count <= cnt;
    last       <= lst;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic send_random_message();
    int n;
    if ($urandom_range(99) < 6) begin
      n = $urandom_range(30, 40);
    end else begin
      n = $urandom_range(0, 3);
    end
    repeat (n) send_item(rand_word(), 3'($urandom_range(7)), 1'b0);
    send_item(rand_word(), 3'($urandom_range(7)), 1'b1);
  endtask

  // Waits until every hash has come out and the back end has had time to go quiet.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_keys(input logic [63:0] k0, input logic [63:0] k1);
    cfg_valid <= 1'b1;
    cfg_index <= sh13_pkg::RegKeyLow;
    cfg_data  <= k0;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= sh13_pkg::RegKeyHigh;
    cfg_data  <= k1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= sh13_pkg::RegKeyLow;
    cfg_data   <= '0;
    push       <= 1'b0;
    word       <= '0;
    byte_count <= '0;
    last       <= 1'b0;
    items_sent = 0;
    idle_en    = 1'b1;
    hold_go    = 1'b0;
    hold_done  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    // Empty message, with stray bits in the unused bytes.
    send_item(Ones, 3'd0, 1'b1);
    send_item(Ones, 3'd7, 1'b1);
    send_item(Ones, 3'd3, 1'b1);
    send_item(64'd0, 3'd1, 1'b1);
    // byte_count on a full word must be ignored.
    send_item(Ones, 3'd5, 1'b0);
    send_item(Ones, 3'd0, 1'b1);
    send_item(64'd0, 3'd0, 1'b0);
    send_item(64'h8000000000000000, 3'd7, 1'b0);
    send_item(64'h0123456789abcdef, 3'd7, 1'b1);
    // A key change while a message is open only applies to the next message.
    send_item(64'h5555555555555555, 3'd2, 1'b0);
    settle();
    write_keys(Ones, Ones);
    send_item(64'haaaaaaaaaaaaaaaa, 3'd4, 1'b1);
    send_item(Ones, 3'd6, 1'b0);
    send_item(Ones, 3'd7, 1'b1);
    settle();
    write_keys(64'd0, 64'd0);
    send_item(64'd0, 3'd0, 1'b0);
    send_item(64'd0, 3'd0, 1'b1);

    for (int phase = 0; items_sent < ItemTarget; phase++) begin
      int phase_end;
      settle();
      case (phase)
        0:       write_keys(Ones, 64'd0);
        1:       write_keys(64'd0, Ones);
        default: write_keys({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      idle_en = (phase != 2);
      if (phase == 1) begin
        hold_go = 1'b1;
      end
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) send_random_message();
    end

    idle_en = 1'b1;
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("siphash_1_3_keyed_hash test passed");
    end else begin
      $display("siphash_1_3_keyed_hash test failed");
    end
    $finish;
  end

endmodule
